// File: rtl/core/cpg_pkg.sv
// Package with the types and constants of the checkerboard pattern generator.
`default_nettype none

package cpg_pkg;

  localparam int CPG_DIM_W   = 13;
  localparam int CPG_LEVEL_W = 8;
  localparam int CPG_MARG_W  = 12;
  localparam int CPG_IDX_W   = 3;
  localparam int CPG_CNT_W   = 4;

  localparam logic [CPG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
  localparam logic [CPG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd1;
  localparam logic [CPG_IDX_W-1:0] REG_SQUARE_SIDE      = 3'd2;
  localparam logic [CPG_IDX_W-1:0] REG_BACKGROUND_LEVEL = 3'd3;
  localparam logic [CPG_IDX_W-1:0] REG_FOREGROUND_LEVEL = 3'd4;

  localparam logic [CPG_DIM_W-1:0]   RST_FRAME_WIDTH      = 13'd640;
  localparam logic [CPG_DIM_W-1:0]   RST_FRAME_HEIGHT     = 13'd480;
  localparam logic [CPG_DIM_W-1:0]   RST_SQUARE_SIDE      = 13'd32;
  localparam logic [CPG_LEVEL_W-1:0] RST_BACKGROUND_LEVEL = 8'd0;
  localparam logic [CPG_LEVEL_W-1:0] RST_FOREGROUND_LEVEL = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PIXEL
  } cpg_state_t;

endpackage

`default_nettype wire

// File: rtl/core/checkerboard_pattern_generator.sv
// Checkerboard test pattern generator with a shared iterative divider for frame geometry.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_start_frame
//   out_    | output    | out_valid/out_stall | out_pixel_value, out_end_of_row, out_end_of_frame
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A pixel transaction: accept in ST_IDLE, then one update of the raster counters in ST_PIXEL.
// At a frame start the transaction first passes ST_DIV, where one restoring divider runs
// 13 steps for the width and then 13 steps for the height before the pixel is made.
// Synchronous reset loads the register defaults and marks a frame start as pending.
// A stalled result waits in the output register while the next transaction is accepted.
`default_nettype none

module checkerboard_pattern_generator #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_start_frame,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [cpg_pkg::CPG_LEVEL_W-1:0]       out_pixel_value,
  output logic                                  out_end_of_row,
  output logic                                  out_end_of_frame,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cpg_pkg::CPG_IDX_W-1:0]    cfg_index,
  input  wire logic [cpg_pkg::CPG_DIM_W-1:0]    cfg_data
);

  import cpg_pkg::*;

  function automatic logic [CPG_DIM_W-1:0] clamp_dim(input logic [CPG_DIM_W-1:0] v);
    logic [CPG_DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CPG_DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      r = CPG_DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

  cpg_state_t state_r, state_nxt;

  logic [CPG_DIM_W-1:0]   frame_width_r, frame_height_r, square_side_r;
  logic [CPG_LEVEL_W-1:0] background_level_r, foreground_level_r;

  logic [CPG_DIM_W-1:0]   w_snap_r, h_snap_r, s_snap_r;
  logic                   pending_r;

  logic [CPG_DIM_W-1:0]   col_r, row_r, pis_r, ris_r, sqd_r, srd_r;
  logic                   col_fg_r, row_fg_r;
  logic [CPG_DIM_W-1:0]   htot_r, vtot_r;
  logic [CPG_MARG_W-1:0]  lmarg_r, tmarg_r;

  logic [CPG_DIM_W:0]     div_rem_r;
  logic [CPG_DIM_W-1:0]   div_quo_r;
  logic [CPG_CNT_W-1:0]   div_cnt_r;
  logic                   div_phase_r;
  logic [CPG_DIM_W-1:0]   hq_r;
  logic [CPG_DIM_W-1:0]   lrem_r;

  logic                   out_valid_r, eor_out_r, eof_out_r;
  logic [CPG_LEVEL_W-1:0] pixel_out_r;

  logic                   accept, div_last, pix_fire;

  logic [CPG_DIM_W:0]     rem_sh, rem_next;
  logic                   div_ge;
  logic [CPG_DIM_W-1:0]   quo_next;

  logic [CPG_DIM_W-1:0]   w_live, h_live;
  logic                   in_rows, in_cols, eor, eof;
  logic [CPG_LEVEL_W-1:0] pix_value;
  logic [CPG_DIM_W:0]     col_inc, row_inc;
  logic [CPG_DIM_W-1:0]   pis_inc, ris_inc;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_start_frame || pending_r) ? ST_DIV : ST_PIXEL;
        end
      end
      ST_DIV: begin
        if (div_phase_r && div_last) begin
          state_nxt = ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        if (pix_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall = 1'b1;
    pix_fire = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_DIV:   in_stall = 1'b1;
      ST_PIXEL: pix_fire = !(out_valid_r && out_stall);
      default:  in_stall = 1'b1;
    endcase
  end

  assign accept    = in_valid && !in_stall;
  assign div_last  = (div_cnt_r == CPG_CNT_W'(CPG_DIM_W - 1));
  assign cfg_ready = 1'b1;

  // One restoring division step.
  always_comb begin
    rem_sh   = {div_rem_r[CPG_DIM_W-1:0], div_quo_r[CPG_DIM_W-1]};
    div_ge   = (rem_sh >= {1'b0, s_snap_r});
    rem_next = div_ge ? (rem_sh - {1'b0, s_snap_r}) : rem_sh;
    quo_next = {div_quo_r[CPG_DIM_W-2:0], div_ge};
  end

  // Pixel decision from the raster counters.
  always_comb begin
    w_live    = clamp_dim(frame_width_r);
    h_live    = clamp_dim(frame_height_r);
    in_rows   = (row_r >= {1'b0, tmarg_r}) && (srd_r < vtot_r);
    in_cols   = (col_r >= {1'b0, lmarg_r}) && (sqd_r < htot_r);
    pix_value = (in_rows && in_cols && col_fg_r) ? foreground_level_r : background_level_r;
    col_inc   = {1'b0, col_r} + (CPG_DIM_W+1)'(1);
    row_inc   = {1'b0, row_r} + (CPG_DIM_W+1)'(1);
    pis_inc   = pis_r + CPG_DIM_W'(1);
    ris_inc   = ris_r + CPG_DIM_W'(1);
    eor       = (col_inc >= {1'b0, w_live});
    eof       = eor && (row_inc >= {1'b0, h_live});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      frame_width_r      <= RST_FRAME_WIDTH;
      frame_height_r     <= RST_FRAME_HEIGHT;
      square_side_r      <= RST_SQUARE_SIDE;
      background_level_r <= RST_BACKGROUND_LEVEL;
      foreground_level_r <= RST_FOREGROUND_LEVEL;
      w_snap_r           <= clamp_dim(RST_FRAME_WIDTH);
      h_snap_r           <= clamp_dim(RST_FRAME_HEIGHT);
      s_snap_r           <= RST_SQUARE_SIDE;
      pending_r          <= 1'b1;
      col_r              <= '0;
      row_r              <= '0;
      pis_r              <= '0;
      ris_r              <= '0;
      sqd_r              <= '0;
      srd_r              <= '0;
      col_fg_r           <= 1'b1;
      row_fg_r           <= 1'b1;
      htot_r             <= '0;
      vtot_r             <= '0;
      lmarg_r            <= '0;
      tmarg_r            <= '0;
      div_cnt_r          <= '0;
      div_phase_r        <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:      frame_width_r      <= cfg_data;
          REG_FRAME_HEIGHT:     frame_height_r     <= cfg_data;
          REG_SQUARE_SIDE:      square_side_r      <= cfg_data;
          REG_BACKGROUND_LEVEL: background_level_r <= cfg_data[CPG_LEVEL_W-1:0];
          REG_FOREGROUND_LEVEL: foreground_level_r <= cfg_data[CPG_LEVEL_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !pix_fire) begin
        out_valid_r <= 1'b0;
      end

      if (accept && (in_start_frame || pending_r)) begin
        div_rem_r   <= '0;
        div_cnt_r   <= '0;
        div_phase_r <= 1'b0;
        if (in_start_frame) begin
          w_snap_r  <= w_live;
          h_snap_r  <= h_live;
          s_snap_r  <= square_side_r;
          div_quo_r <= w_live;
          col_r     <= '0;
          row_r     <= '0;
          pis_r     <= '0;
          ris_r     <= '0;
          sqd_r     <= '0;
          srd_r     <= '0;
          col_fg_r  <= 1'b1;
          row_fg_r  <= 1'b1;
        end else begin
          div_quo_r <= w_snap_r;
        end
      end

      if (state_r == ST_DIV) begin
        if (!div_last) begin
          div_rem_r <= rem_next;
          div_quo_r <= quo_next;
          div_cnt_r <= div_cnt_r + CPG_CNT_W'(1);
        end else if (!div_phase_r) begin
          hq_r        <= quo_next;
          lrem_r      <= rem_next[CPG_DIM_W-1:0];
          div_rem_r   <= '0;
          div_quo_r   <= h_snap_r;
          div_cnt_r   <= '0;
          div_phase_r <= 1'b1;
        end else begin
          pending_r <= 1'b0;
          if ((s_snap_r == '0) || (hq_r == '0) || (quo_next == '0)) begin
            htot_r  <= '0;
            vtot_r  <= '0;
            lmarg_r <= '0;
            tmarg_r <= '0;
          end else begin
            htot_r  <= hq_r;
            vtot_r  <= quo_next;
            lmarg_r <= lrem_r[CPG_DIM_W-1:1];
            tmarg_r <= rem_next[CPG_DIM_W-1:1];
          end
        end
      end

      if (pix_fire) begin
        out_valid_r <= 1'b1;
        pixel_out_r <= pix_value;
        eor_out_r   <= eor;
        eof_out_r   <= eof;
        if (eof) begin
          col_r     <= '0;
          row_r     <= '0;
          pis_r     <= '0;
          ris_r     <= '0;
          sqd_r     <= '0;
          srd_r     <= '0;
          col_fg_r  <= 1'b1;
          row_fg_r  <= 1'b1;
          pending_r <= 1'b1;
          w_snap_r  <= w_live;
          h_snap_r  <= h_live;
          s_snap_r  <= square_side_r;
        end else if (eor) begin
          col_r <= '0;
          pis_r <= '0;
          sqd_r <= '0;
          row_r <= row_inc[CPG_DIM_W-1:0];
          if (in_rows && (ris_inc >= square_side_r)) begin
            ris_r    <= '0;
            srd_r    <= srd_r + CPG_DIM_W'(1);
            row_fg_r <= !row_fg_r;
            col_fg_r <= !row_fg_r;
          end else begin
            if (in_rows) begin
              ris_r <= ris_inc;
            end
            col_fg_r <= row_fg_r;
          end
        end else begin
          col_r <= col_inc[CPG_DIM_W-1:0];
          if (in_rows && in_cols) begin
            if (pis_inc >= square_side_r) begin
              pis_r    <= '0;
              sqd_r    <= sqd_r + CPG_DIM_W'(1);
              col_fg_r <= !col_fg_r;
            end else begin
              pis_r <= pis_inc;
            end
          end
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = pixel_out_r;
  assign out_end_of_row   = eor_out_r;
  assign out_end_of_frame = eof_out_r;

  a_start_runs_divider: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_start_frame) |=> (state_r == ST_DIV))
    else $error("Frame start transaction did not enter the divider.");

  a_result_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_PIXEL))
    else $error("Result appeared without a pixel update.");

  a_divider_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= CPG_CNT_W'(CPG_DIM_W - 1)))
    else $error("Divider step count ran past its end.");

  a_pixel_needs_geometry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIXEL) |-> !pending_r)
    else $error("Pixel update with frame geometry still pending.");

endmodule

`default_nettype wire

// File: bench/tb_checkerboard_pattern_generator.sv
// Self-checking testbench for the checkerboard pattern generator with a raster predictor.
module tb_checkerboard_pattern_generator;
  import cpg_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam int SETTLE_CYCLES = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEM_TARGET = 950;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CPG_LEVEL_W-1:0] level;
    logic                   row_end;
    logic                   frame_end;
  } pixel_t;

  typedef struct packed {
    logic [CPG_IDX_W-1:0] index;
    logic [CPG_DIM_W-1:0] data;
  } reg_write_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_profile_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_start_frame = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CPG_LEVEL_W-1:0] out_pixel_value;
  logic                   out_end_of_row;
  logic                   out_end_of_frame;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CPG_IDX_W-1:0]   cfg_index = REG_FRAME_WIDTH;
  logic [CPG_DIM_W-1:0]   cfg_data = '0;

  int unsigned cfg_width, cfg_height, cfg_side;
  logic [CPG_LEVEL_W-1:0] cfg_bg, cfg_fg;

  int unsigned col_pos, row_pos, run_in_square, lines_in_square;
  int unsigned squares_across_done, squares_down_done;
  int unsigned squares_across, squares_down, margin_left, margin_top;
  bit col_is_fg, row_is_fg;

  logic       pending_starts[$];
  pixel_t     expected_pixels[$];
  reg_write_t write_list[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_queued = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  checkerboard_pattern_generator #(.MAX_DIMENSION(MAX_DIM)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned limit_dimension(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void latch_frame_geometry();
    int unsigned w, h, across, down;
    w = limit_dimension(cfg_width);
    h = limit_dimension(cfg_height);
    across = 0;
    down = 0;
    col_pos = 0;
    row_pos = 0;
    run_in_square = 0;
    lines_in_square = 0;
    squares_across_done = 0;
    squares_down_done = 0;
    col_is_fg = 1'b1;
    row_is_fg = 1'b1;
    if (cfg_side != 0) begin
      across = w / cfg_side;
      down = h / cfg_side;
    end
    if (across == 0 || down == 0) begin
      squares_across = 0;
      squares_down = 0;
      margin_left = 0;
      margin_top = 0;
    end else begin
      squares_across = across;
      squares_down = down;
      margin_left = (w - across * cfg_side) / 2;
      margin_top = (h - down * cfg_side) / 2;
    end
  endfunction

  function automatic pixel_t predict_pixel(input logic start);
    int unsigned w, h;
    bit rows_on, cols_on;
    pixel_t px;
    if (start) latch_frame_geometry();
    w = limit_dimension(cfg_width);
    h = limit_dimension(cfg_height);
    rows_on = (row_pos >= margin_top) && (squares_down_done < squares_down);
    cols_on = (col_pos >= margin_left) && (squares_across_done < squares_across);
    px.level = cfg_bg;
    if (rows_on && cols_on) begin
      if (col_is_fg) px.level = cfg_fg;
      run_in_square++;
      if (run_in_square >= cfg_side) begin
        run_in_square = 0;
        squares_across_done++;
        col_is_fg = !col_is_fg;
      end
    end
    px.row_end = (col_pos + 1) >= w;
    px.frame_end = px.row_end && ((row_pos + 1) >= h);
    if (px.frame_end) begin
      latch_frame_geometry();
    end else if (px.row_end) begin
      col_pos = 0;
      run_in_square = 0;
      squares_across_done = 0;
      if (rows_on) begin
        lines_in_square++;
        if (lines_in_square >= cfg_side) begin
          lines_in_square = 0;
          squares_down_done++;
          row_is_fg = !row_is_fg;
        end
      end
      col_is_fg = row_is_fg;
      row_pos++;
    end else begin
      col_pos++;
    end
    return px;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  function automatic void set_idling(input idle_profile_t profile);
    case (profile)
      IDLE_NONE: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 55;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        recv_stall_pct = 55;
      end
      default: begin
        send_gap_pct = 6;
        recv_stall_pct = 6;
      end
    endcase
  endfunction

  function automatic void queue_items(input int unsigned count, input bit first_start,
                                      input int unsigned start_pct);
    for (int unsigned k = 0; k < count; k++) begin
      pending_starts.push_back(k == 0 ? first_start : ($urandom_range(0, 99) < start_pct));
    end
    items_queued += count;
  endfunction

  function automatic void stage_write(input logic [CPG_IDX_W-1:0] index,
                                      input int unsigned data);
    reg_write_t wr;
    wr.index = index;
    wr.data = data[CPG_DIM_W-1:0];
    write_list.push_back(wr);
  endfunction

  function automatic int unsigned pick_dimension(input int unsigned typical_max);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(0, (1 << CPG_DIM_W) - 1);
    return $urandom_range(1, typical_max);
  endfunction

  task automatic apply_writes();
    reg_write_t wr;
    while (write_list.size() != 0) begin
      wr = write_list.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.index;
      cfg_data <= wr.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (wr.index)
        REG_FRAME_WIDTH:      cfg_width = wr.data;
        REG_FRAME_HEIGHT:     cfg_height = wr.data;
        REG_SQUARE_SIDE:      cfg_side = wr.data;
        REG_BACKGROUND_LEVEL: cfg_bg = wr.data[CPG_LEVEL_W-1:0];
        REG_FOREGROUND_LEVEL: cfg_fg = wr.data[CPG_LEVEL_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_starts.size() != 0 || in_valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_start_frame <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(predict_pixel(in_start_frame));
      end
      if (!in_valid || !in_stall) begin
        if (pending_starts.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_start_frame <= pending_starts.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch($sformatf("pixel %0d arrived with nothing expected", out_pixel_value));
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_value !== want.level) begin
            note_mismatch($sformatf("pixel_value expected %0d got %0d",
                                    want.level, out_pixel_value));
          end
          if (out_end_of_row !== want.row_end) begin
            note_mismatch($sformatf("end_of_row expected %0b got %0b",
                                    want.row_end, out_end_of_row));
          end
          if (out_end_of_frame !== want.frame_end) begin
            note_mismatch($sformatf("end_of_frame expected %0b got %0b",
                                    want.frame_end, out_end_of_frame));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned level;
    cfg_width = RST_FRAME_WIDTH;
    cfg_height = RST_FRAME_HEIGHT;
    cfg_side = RST_SQUARE_SIDE;
    cfg_bg = RST_BACKGROUND_LEVEL;
    cfg_fg = RST_FOREGROUND_LEVEL;
    latch_frame_geometry();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(IDLE_NONE);
    queue_items(3, 1'b0, 0);
    settle();

    set_idling(IDLE_SENDER);
    stage_write(REG_FRAME_WIDTH, 0);
    stage_write(REG_FRAME_HEIGHT, 0);
    stage_write(REG_SQUARE_SIDE, 3);
    apply_writes();
    queue_items(2, 1'b0, 0);
    settle();

    set_idling(IDLE_RECEIVER);
    stage_write(REG_FRAME_WIDTH, (1 << CPG_DIM_W) - 1);
    stage_write(REG_FRAME_HEIGHT, 5000);
    stage_write(REG_SQUARE_SIDE, MAX_DIM);
    stage_write(REG_BACKGROUND_LEVEL, 'h5A);
    stage_write(REG_FOREGROUND_LEVEL, 'hA5);
    apply_writes();
    queue_items(4, 1'b1, 0);
    settle();

    set_idling(IDLE_BOTH);
    stage_write(REG_FRAME_WIDTH, 7);
    stage_write(REG_FRAME_HEIGHT, 5);
    stage_write(REG_SQUARE_SIDE, 2);
    for (int k = int'(REG_FOREGROUND_LEVEL) + 1; k < (1 << CPG_IDX_W); k++) begin
      stage_write(CPG_IDX_W'(k), (1 << CPG_DIM_W) - 1);
    end
    apply_writes();
    queue_items(8, 1'b1, 0);
    settle();

    set_idling(IDLE_NONE);
    stage_write(REG_FRAME_WIDTH, 3);
    stage_write(REG_FRAME_HEIGHT, 2);
    stage_write(REG_SQUARE_SIDE, 1);
    stage_write(REG_BACKGROUND_LEVEL, 'h33);
    stage_write(REG_FOREGROUND_LEVEL, 'h33);
    apply_writes();
    queue_items(5, 1'b1, 0);
    settle();

    stage_write(REG_FRAME_WIDTH, 4);
    stage_write(REG_FRAME_HEIGHT, 1);
    stage_write(REG_SQUARE_SIDE, 0);
    apply_writes();
    queue_items(3, 1'b1, 0);
    settle();

    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      set_idling(idle_profile_t'(phase % 4));
      if ($urandom_range(0, 9) != 0) stage_write(REG_FRAME_WIDTH, pick_dimension(12));
      if ($urandom_range(0, 9) != 0) stage_write(REG_FRAME_HEIGHT, pick_dimension(8));
      if ($urandom_range(0, 9) != 0) stage_write(REG_SQUARE_SIDE, pick_dimension(5));
      level = $urandom_range(0, (1 << CPG_DIM_W) - 1);
      if ($urandom_range(0, 3) != 0) stage_write(REG_BACKGROUND_LEVEL, level);
      if ($urandom_range(0, 3) != 0) begin
        stage_write(REG_FOREGROUND_LEVEL,
                    ($urandom_range(0, 7) == 0) ? level
                                                : $urandom_range(0, (1 << CPG_DIM_W) - 1));
      end
      if ($urandom_range(0, 15) == 0) begin
        stage_write(CPG_IDX_W'($urandom_range(int'(REG_FOREGROUND_LEVEL) + 1,
                                              (1 << CPG_IDX_W) - 1)),
                    $urandom_range(0, (1 << CPG_DIM_W) - 1));
      end
      apply_writes();
      queue_items($urandom_range(15, 50), $urandom_range(0, 3) != 0, 3);
      settle();
      phase++;
    end

    if (expected_pixels.size() != 0) begin
      note_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
